/* design/tsp_pkg.sv */
package tsp_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PROD_W  = 25;             // 9 bit scaled span by 16 bit step
    localparam int unsigned CNT_W   = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    // phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_DECEL = 2'd3;

    // register indexes
    localparam logic [1:0] REG_SLOW = 2'd0;
    localparam logic [1:0] REG_FAST = 2'd1;
    localparam logic [1:0] REG_RAMP = 2'd2;
    localparam logic [1:0] REG_RUN  = 2'd3;

    localparam logic [DATA_W-1:0] SLOW_RST = 16'd10000;
    localparam logic [DATA_W-1:0] FAST_RST = 16'd1000;
    localparam logic [DATA_W-1:0] RAMP_RST = 16'd300;
    localparam logic [DATA_W-1:0] RUN_RST  = 16'd5000;
    localparam logic [3:0]        COIL_RST = 4'hf;

    typedef struct packed {
        logic [DATA_W-1:0] slow;
        logic [DATA_W-1:0] fast;
        logic [DATA_W-1:0] ramp;
        logic [DATA_W-1:0] run;
    } t_cfg;

    typedef struct packed {
        logic accept;      // take the input item
        logic mul;         // form the scaled step product
        logic div_step;    // one restoring divider iteration
        logic int_load;    // load interval from the quotient
    } t_cmd;

    typedef struct packed {
        logic need_div;    // accepted item needs a new ramp interval
    } t_sts;

    typedef struct packed {
        logic [3:0] coil;
        logic       pulse;
        logic       busy;
        logic       done;
    } t_res;

    function automatic logic [3:0] half_step(input logic [2:0] pos);
        logic [3:0] v;
        case (pos)
            3'd0:    v = 4'h1;
            3'd1:    v = 4'h3;
            3'd2:    v = 4'h2;
            3'd3:    v = 4'h6;
            3'd4:    v = 4'h4;
            3'd5:    v = 4'hc;
            3'd6:    v = 4'h8;
            default: v = 4'h9;
        endcase
        return v;
    endfunction

endpackage

/* design/tsp_ctrl.sv */
module tsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_out_free,
    input  tsp_pkg::t_sts i_sts,
    output logic          o_s_ready,
    output tsp_pkg::t_cmd o_cmd
);
    import tsp_pkg::*;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_s_ready = (r_state == ST_READY) && i_out_free;
    assign w_accept  = o_s_ready && i_s_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.accept = w_accept;
        case (r_state)
            ST_READY: begin
                if (w_accept && i_sts.need_div) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.int_load = 1'b1;
                n_state = ST_READY;
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/tsp_dp.sv */
module tsp_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsp_pkg::t_cfg i_cfg,
    input  tsp_pkg::t_cmd i_cmd,
    input  logic          i_mode,
    input  logic          i_dir,
    output tsp_pkg::t_sts o_sts,
    output tsp_pkg::t_res o_res
);
    import tsp_pkg::*;

    logic [1:0]        r_phase, n_phase;
    logic [DATA_W-1:0] r_step, n_step;
    logic [DATA_W-1:0] r_tick, n_tick;
    logic [DATA_W-1:0] r_interval, n_interval;
    logic [2:0]        r_pos, n_pos;
    logic              r_dir, n_dir;
    logic [3:0]        r_coil, n_coil;
    logic [PROD_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_rem;

    logic              w_pulse, w_done, w_need_div;
    logic [DATA_W-1:0] w_tick_inc, w_step_inc, w_len, w_diff, w_off;
    logic [1:0]        w_enter;
    logic [DATA_W:0]   w_rem_sh, w_rem_sub;
    logic              w_qbit;

    // first non-empty phase at or after p
    function automatic logic [1:0] live_phase(input logic [1:0] p, input logic ramp_nz,
                                              input logic run_nz);
        logic [1:0] q;
        case (p)
            PH_ACCEL: q = ramp_nz ? PH_ACCEL : (run_nz ? PH_RUN : PH_IDLE);
            PH_RUN:   q = run_nz ? PH_RUN : (ramp_nz ? PH_DECEL : PH_IDLE);
            PH_DECEL: q = ramp_nz ? PH_DECEL : PH_IDLE;
            default:  q = PH_IDLE;
        endcase
        return q;
    endfunction

    assign w_tick_inc = r_tick + 16'd1;
    assign w_step_inc = r_step + 16'd1;
    assign w_len      = (r_phase == PH_RUN) ? i_cfg.run : i_cfg.ramp;
    assign w_diff     = (i_cfg.slow > i_cfg.fast) ? (i_cfg.slow - i_cfg.fast) : '0;
    assign w_off      = {r_dvd[8:0], 7'd0};

    // restoring divider iteration
    assign w_rem_sh  = {r_rem, r_dvd[PROD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, i_cfg.ramp};
    assign w_qbit    = (w_rem_sh >= {1'b0, i_cfg.ramp});

    always_comb begin
        n_phase    = r_phase;
        n_step     = r_step;
        n_tick     = r_tick;
        n_interval = r_interval;
        n_pos      = r_pos;
        n_dir      = r_dir;
        n_coil     = r_coil;
        w_pulse    = 1'b0;
        w_done     = 1'b0;
        w_need_div = 1'b0;
        w_enter    = PH_IDLE;
        if (r_phase == PH_IDLE) begin
            if (i_mode) begin
                n_dir   = i_dir;
                w_enter = live_phase(PH_ACCEL, |i_cfg.ramp, |i_cfg.run);
                n_phase = w_enter;
                n_step  = '0;
                n_tick  = '0;
                if (w_enter == PH_IDLE) begin
                    w_done = 1'b1;
                end else begin
                    n_interval = (w_enter == PH_ACCEL) ? i_cfg.slow : i_cfg.fast;
                end
            end
        end else if (!i_mode) begin
            if (w_tick_inc >= r_interval) begin
                n_coil  = half_step(r_pos);
                n_pos   = r_dir ? (r_pos - 3'd1) : (r_pos + 3'd1);
                w_pulse = 1'b1;
                n_tick  = '0;
                if (w_step_inc >= w_len) begin
                    w_enter = live_phase(r_phase + 2'd1, |i_cfg.ramp, |i_cfg.run);
                    n_phase = w_enter;
                    n_step  = '0;
                    if (w_enter == PH_IDLE) begin
                        w_done = 1'b1;
                    end else begin
                        n_interval = (w_enter == PH_ACCEL) ? i_cfg.slow : i_cfg.fast;
                    end
                end else begin
                    n_step = w_step_inc;
                    if (r_phase == PH_RUN) begin
                        n_interval = i_cfg.fast;
                    end else begin
                        w_need_div = 1'b1;
                    end
                end
            end else begin
                n_tick = w_tick_inc;
            end
        end
    end

    assign o_sts.need_div = w_need_div;
    assign o_res.coil     = n_coil;
    assign o_res.pulse    = w_pulse;
    assign o_res.busy     = (n_phase != PH_IDLE);
    assign o_res.done     = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_step     <= '0;
            r_tick     <= '0;
            r_interval <= '0;
            r_pos      <= '0;
            r_dir      <= 1'b0;
            r_coil     <= COIL_RST;
        end else if (i_cmd.accept) begin
            r_phase    <= n_phase;
            r_step     <= n_step;
            r_tick     <= n_tick;
            r_interval <= n_interval;
            r_pos      <= n_pos;
            r_dir      <= n_dir;
            r_coil     <= n_coil;
        end else if (i_cmd.int_load) begin
            r_interval <= (r_phase == PH_ACCEL) ? (i_cfg.slow - w_off) : (i_cfg.fast + w_off);
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dvd <= {16'd0, w_diff[15:7]} * {9'd0, r_step};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[PROD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
        end
    end

endmodule

/* design/trapezoidal_stepper_profile_core.sv */
// trapezoidal half-step stepper profile: each input item is either a timer tick
// (tuser 0) or a move start (tuser 1, direction in tdata bit 0); every item gives
// exactly one result item carrying the coil pattern, a step pulse, busy and a
// move-done flag on tlast. a start acts only while idle (a start during a move is
// taken and ignored) and runs acceleration (ramp_steps half steps from slow_delay
// toward fast_delay in multiples of 128 ticks), run (run_steps at fast_delay) and
// deceleration (mirror of the ramp); empty phases are skipped. ticks, starts and
// other steps need only the accept; a half step inside a ramp runs a sequence before
// the next item is taken: the accept, the 9x16 multiply of the scaled speed span by
// the step count, the one-bit-per-cycle restoring divider by ramp_steps, and the
// load of the new interval. results sit in an output register, so an item is taken
// in the same cycle the previous result leaves. registers are at byte addresses 0
// (slow_delay), 4 (fast_delay), 8 (ramp_steps), 12 (run_steps); a write during a
// move takes effect at the next read of that register, and is to be made only while
// no item is in progress, which the block itself does not enforce
module trapezoidal_stepper_profile_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] direction, [7:1] zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] mode: 0 tick, 1 start
    // result item stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] coil_pattern, [4] step_pulse,
                                          // [5] busy_res, [7:6] zero
    output logic        o_m_axis_tlast,   // move_done
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tsp_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    t_res w_res;
    t_res r_res;
    logic r_m_valid;
    logic w_out_free;
    logic w_cfg_wr;

    // ---- configuration registers ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow <= SLOW_RST;
            r_cfg.fast <= FAST_RST;
            r_cfg.ramp <= RAMP_RST;
            r_cfg.run  <= RUN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SLOW: r_cfg.slow <= pwdata[15:0];
                REG_FAST: r_cfg.fast <= pwdata[15:0];
                REG_RAMP: r_cfg.ramp <= pwdata[15:0];
                REG_RUN:  r_cfg.run  <= pwdata[15:0];
                default:  r_cfg.run  <= r_cfg.run;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SLOW: prdata = {16'd0, r_cfg.slow};
            REG_FAST: prdata = {16'd0, r_cfg.fast};
            REG_RAMP: prdata = {16'd0, r_cfg.ramp};
            REG_RUN:  prdata = {16'd0, r_cfg.run};
            default:  prdata = '0;
        endcase
    end

    // ---- sequencer and profile datapath ----
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_s_ready  (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tsp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_cmd),
        .i_mode  (i_s_axis_tuser[0]),
        .i_dir   (i_s_axis_tdata[0]),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.accept) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_res.busy, r_res.pulse, r_res.coil};
    assign o_m_axis_tlast  = r_res.done;

endmodule
